[design/jet_pkg.sv]
// Constants, register indexes and saturation helper for the Julia escape-time block.
`timescale 1ns / 1ps
`default_nettype none
package jet_pkg;

  // Q4.28 fixed point
  localparam int unsigned FracBits = 28;
  localparam int unsigned QWidth   = 32;
  localparam int unsigned CWidth   = 31;
  localparam int unsigned CntWidth = 16;

  // sum of squares at or above 4.0 in Q8.56 has a bit set at or above this one
  localparam int unsigned EscBit = 2 * FracBits + 2;

  // width of a new component before saturation
  localparam int unsigned SumWidth = 38;

  localparam logic [CntWidth-1:0] MaxIterReset = 16'd256;

  typedef logic [1:0] reg_index_t;
  localparam reg_index_t REG_C_REAL   = 2'd0;
  localparam reg_index_t REG_C_IMAG   = 2'd1;
  localparam reg_index_t REG_MAX_ITER = 2'd2;

  typedef logic signed [QWidth-1:0]   q_t;
  typedef logic signed [CWidth-1:0]   c_t;
  typedef logic signed [SumWidth-1:0] sum_t;

  // clamp a widened component back into the Q4.28 range
  function automatic q_t sat_q(input sum_t v);
    logic hi_same;
    hi_same = (v[SumWidth-1:QWidth-1] == {(SumWidth-QWidth+1){1'b0}}) ||
              (v[SumWidth-1:QWidth-1] == {(SumWidth-QWidth+1){1'b1}});
    if (hi_same) begin
      sat_q = v[QWidth-1:0];
    end else if (v[SumWidth-1]) begin
      sat_q = {1'b1, {(QWidth-1){1'b0}}};
    end else begin
      sat_q = {1'b0, {(QWidth-1){1'b1}}};
    end
  endfunction

endpackage
`default_nettype wire

[design/julia_escape_time.sv]
// Julia escape-time iterator: z <- z*z + c on one shared 32x32 multiplier.
//
//  channel | direction | signals
//  --------+-----------+------------------------------------------------
//  in      | in        | in_valid, in_ready, z_real, z_imag
//  out     | out       | out_valid, out_ready, iteration_count
//  cfg     | in        | cfg_we, cfg_index, cfg_data (no read-back)
//
// Each iteration runs three products through the single signed 32x32
// multiplier (re*re, im*im, re*im) and one update/escape step. The count
// shows when the limit stops the point or when it escapes, once the result
// register is free. in_ready is high only while no point is in work; a
// finished point holds until the result register is free. Reset (rst,
// synchronous) sets c to 0, limit 256.
`timescale 1ns / 1ps
`default_nettype none
module julia_escape_time (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output      logic                            in_ready,
  input  wire logic signed [31:0]              z_real,
  input  wire logic signed [31:0]              z_imag,
  output      logic                            out_valid,
  input  wire logic                            out_ready,
  output      logic [15:0]                     iteration_count,
  input  wire logic                            cfg_we,
  input  wire jet_pkg::reg_index_t             cfg_index,
  input  wire logic [30:0]                     cfg_data
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SQ_RE  = 3'd1;
  localparam logic [2:0] S_SQ_IM  = 3'd2;
  localparam logic [2:0] S_CROSS  = 3'd3;
  localparam logic [2:0] S_UPDATE = 3'd4;
  localparam logic [2:0] S_DONE   = 3'd5;

  localparam int unsigned QW = jet_pkg::QWidth;
  localparam int unsigned PW = 2 * QW;
  localparam int unsigned FB = jet_pkg::FracBits;
  localparam int unsigned SW = jet_pkg::SumWidth;
  localparam int unsigned CW = jet_pkg::CWidth;

  logic [2:0]                    state;
  jet_pkg::c_t                   c_real;
  jet_pkg::c_t                   c_imag;
  logic [jet_pkg::CntWidth-1:0]  max_iterations;
  logic [jet_pkg::CntWidth-1:0]  count;
  jet_pkg::q_t                   zr;
  jet_pkg::q_t                   zi;
  logic signed [PW-1:0]          prod;
  logic [PW-2:0]                 sq_re;
  logic [PW-1:0]                 mag;
  logic signed [PW-1:0]          diff;

  jet_pkg::q_t                   op_a;
  jet_pkg::q_t                   op_b;
  logic signed [PW-1:0]          mult;
  jet_pkg::sum_t                 nr_sum;
  jet_pkg::sum_t                 ni_sum;
  logic                          escape;
  logic                          out_load;

  assign in_ready = (state == S_IDLE);
  assign out_load = (state == S_DONE) && (!out_valid || out_ready);

  // operand select for the shared multiplier
  always_comb begin
    unique case (state)
      S_SQ_RE: begin
        op_a = zr;
        op_b = zr;
      end
      S_SQ_IM: begin
        op_a = zi;
        op_b = zi;
      end
      default: begin
        op_a = zr;
        op_b = zi;
      end
    endcase
  end

  assign mult = op_a * op_b;

  assign escape = |mag[PW-1:jet_pkg::EscBit];

  // floor(diff / 2^28) + c_real, floor(re*im / 2^27) + c_imag
  assign nr_sum = {{(SW-(PW-FB)){diff[PW-1]}}, diff[PW-1:FB]} +
                  {{(SW-CW){c_real[CW-1]}}, c_real};
  assign ni_sum = {{(SW-(PW-FB+1)){prod[PW-1]}}, prod[PW-1:FB-1]} +
                  {{(SW-CW){c_imag[CW-1]}}, c_imag};

  always_ff @(posedge clk) begin
    if (rst) begin
      c_real         <= '0;
      c_imag         <= '0;
      max_iterations <= jet_pkg::MaxIterReset;
    end else if (cfg_we) begin
      unique case (cfg_index)
        jet_pkg::REG_C_REAL:   c_real         <= cfg_data;
        jet_pkg::REG_C_IMAG:   c_imag         <= cfg_data;
        jet_pkg::REG_MAX_ITER: max_iterations <= cfg_data[jet_pkg::CntWidth-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_SQ_RE;
          end
        end
        S_SQ_RE: begin
          if (count >= max_iterations) begin
            state <= S_DONE;
          end else begin
            state <= S_SQ_IM;
          end
        end
        S_SQ_IM:  state <= S_CROSS;
        S_CROSS:  state <= S_UPDATE;
        S_UPDATE: begin
          if (escape) begin
            state <= S_DONE;
          end else begin
            state <= S_SQ_RE;
          end
        end
        S_DONE: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath, no reset needed
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        zr    <= z_real;
        zi    <= z_imag;
        count <= '0;
      end
      S_SQ_RE: prod <= mult;
      S_SQ_IM: begin
        sq_re <= prod[PW-2:0];
        prod  <= mult;
      end
      S_CROSS: begin
        mag  <= {1'b0, sq_re} + {1'b0, prod[PW-2:0]};
        diff <= $signed({1'b0, sq_re}) - $signed({1'b0, prod[PW-2:0]});
        prod <= mult;
      end
      S_UPDATE: begin
        if (!escape) begin
          zr    <= jet_pkg::sat_q(nr_sum);
          zi    <= jet_pkg::sat_q(ni_sum);
          count <= count + 1'b1;
        end
      end
      default: begin
      end
    endcase
    if (out_load) begin
      iteration_count <= count;
    end
  end

`ifndef SYNTH
  // a point once taken keeps the input closed for the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input open right after a word was taken");

  // an escaping point finishes without another iteration
  a_escape_ends: assert property (@(posedge clk) disable iff (rst)
    (state == S_UPDATE && escape) |=> (state == S_DONE) && $stable(count))
    else $error("escape did not end the iteration");

  // a handed-over result leaves the block idle with the word shown
  a_done_handover: assert property (@(posedge clk) disable iff (rst)
    out_load |=> (out_valid && in_ready && iteration_count == $past(count)))
    else $error("result handover broken");
`endif

endmodule
`default_nettype wire
